@@ src/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

    // Queue capacity and stored value width.
    localparam int unsigned DEPTH       = 16;
    localparam int unsigned VALUE_WIDTH = 32;

    // Widths of the stream fields.
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned FIELD_W   = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned OCC_W     = 5;
    localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
    localparam int unsigned IN_DATA_W  = ((FIELD_W + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_W = ((FIELD_W + OCC_W + 7) / 8) * 8;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [CNT_W-1:0]       t_count;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_PEEK   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic   en;
        t_cmd   cmd;
        t_value new_value;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ src/spq_cell.sv @@
`default_nettype none

module spq_cell (
    input  wire logic               i_clk,
    input  wire spq_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_occupied,
    input  wire logic               i_left_ins,
    input  wire spq_pkg::t_value    i_left_value,
    input  wire spq_pkg::t_value    i_right_value,
    output logic                    o_ins,
    output spq_pkg::t_value         o_value
);

    spq_pkg::t_value r_value;
    spq_pkg::t_value n_value;

    // The new value belongs at or before this cell when the cell is free or smaller.
    assign o_ins   = !i_occupied || ($signed(i_ctl.new_value) > $signed(r_value));
    assign o_value = r_value;

    // Insert shifts down from the insertion point; remove shifts everything up.
    always_comb begin
        n_value = r_value;
        if (i_ctl.en) begin
            unique case (i_ctl.cmd)
                spq_pkg::CMD_INSERT: begin
                    if (i_left_ins) begin
                        n_value = i_left_value;
                    end else if (o_ins) begin
                        n_value = i_ctl.new_value;
                    end
                end
                spq_pkg::CMD_REMOVE: begin
                    n_value = i_right_value;
                end
                default: begin
                    n_value = r_value;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

@@ src/sorted_priority_queue.sv @@
// Bounded max-priority queue held as a row of DEPTH cells in descending order,
// cell 0 holding the largest value. The command travels in s_axis_tuser and the
// value in s_axis_tdata; every transfer in gives exactly one result transfer out
// carrying the largest value held before the command, a status and the
// occupancy after it. The queue takes one command per clock while the output
// register is free or its result is being taken: every cell compares the
// broadcast value against its own entry in the same cycle and shifts toward or
// away from its neighbor, so the row's compare-and-shift sets the rate. A
// result appears in the output register in the cycle after its command is
// taken, and a new command is accepted while that result is being taken. An
// insert into a full queue is dropped with the full status; a peek or remove
// on an empty queue reports empty with a zero value.
`default_nettype none

module sorted_priority_queue (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] value
    input  wire logic [spq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  wire logic [spq_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [31:0] top_value, [36:32] occupancy, upper bits zero
    output logic [spq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [1:0] status
    output logic [spq_pkg::STATUS_W-1:0]        m_axis_tuser
);

    localparam int unsigned DEPTH = spq_pkg::DEPTH;

    spq_pkg::t_count           r_count;
    spq_pkg::t_count           n_count;
    logic                      r_m_valid;
    logic [spq_pkg::FIELD_W-1:0] r_top;
    logic [spq_pkg::OCC_W-1:0]   r_occ;
    spq_pkg::t_status          r_status;
    spq_pkg::t_status          n_status;

    logic                      w_accept;
    logic                      w_empty;
    logic                      w_full;
    spq_pkg::t_cmd             w_cmd;
    spq_pkg::t_value           w_in_value;
    spq_pkg::t_cell_ctl        w_ctl;
    logic [spq_pkg::FIELD_W-1:0] w_top;

    logic                      w_ins   [DEPTH];
    spq_pkg::t_value           w_value [DEPTH];

    // Input handshake: the output register frees up when its result is taken.
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_cmd      = spq_pkg::t_cmd'(s_axis_tuser);
    assign w_in_value = spq_pkg::t_value'($signed(s_axis_tdata[spq_pkg::FIELD_W-1:0]));
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == spq_pkg::CNT_W'(DEPTH));
    assign w_top      = w_empty ? '0 : spq_pkg::FIELD_W'($signed(w_value[0]));

    // Cells only move when the command changes the stored contents.
    always_comb begin
        w_ctl.cmd       = w_cmd;
        w_ctl.new_value = w_in_value;
        w_ctl.en        = w_accept
                          && !((w_cmd == spq_pkg::CMD_INSERT) && w_full)
                          && !((w_cmd == spq_pkg::CMD_REMOVE) && w_empty);
    end

    // Row of cells, each linked to its left and right neighbor.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic            w_occupied;
        logic            w_left_ins;
        spq_pkg::t_value w_left_value;
        spq_pkg::t_value w_right_value;

        assign w_occupied = (spq_pkg::CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_first
            assign w_left_ins   = 1'b0;
            assign w_left_value = w_in_value;
        end else begin : g_inner
            assign w_left_ins   = w_ins[gi-1];
            assign w_left_value = w_value[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_right_value = w_value[gi];
        end else begin : g_body
            assign w_right_value = w_value[gi+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_occupied    (w_occupied),
            .i_left_ins    (w_left_ins),
            .i_left_value  (w_left_value),
            .i_right_value (w_right_value),
            .o_ins         (w_ins[gi]),
            .o_value       (w_value[gi])
        );
    end

    // Occupancy and status for the command being taken.
    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        unique case (w_cmd)
            spq_pkg::CMD_INSERT: begin
                if (w_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            spq_pkg::CMD_PEEK: begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end
            end
            spq_pkg::CMD_REMOVE: begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            spq_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (s_axis_tready) begin
                r_m_valid <= s_axis_tvalid;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_top    <= w_top;
            r_status <= n_status;
            r_occ    <= spq_pkg::OCC_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = spq_pkg::OUT_DATA_W'({r_occ, r_top});

endmodule

`default_nettype wire

@@ src/spq_checker.sv @@
`default_nettype none

module spq_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tready,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [spq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic [spq_pkg::STATUS_W-1:0]   m_axis_tuser
);

    localparam int unsigned OCC_LO = spq_pkg::FIELD_W;
    localparam int unsigned OCC_HI = spq_pkg::FIELD_W + spq_pkg::OCC_W - 1;

    logic [spq_pkg::OCC_W-1:0] w_occ;
    assign w_occ = m_axis_tdata[OCC_HI:OCC_LO];

    // A full report means the queue held exactly its capacity.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == spq_pkg::ST_FULL)
        |-> (w_occ == spq_pkg::OCC_W'(spq_pkg::DEPTH)))
        else $error("full status with occupancy other than capacity");

    // An empty report carries a zero value and an empty queue.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == spq_pkg::ST_EMPTY)
        |-> (m_axis_tdata[spq_pkg::FIELD_W-1:0] == '0) && (w_occ == '0))
        else $error("empty status with nonzero value or occupancy");

    // The queue can take a command whenever no result waits.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

    // A stalled result holds steady.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire

@@ bench/sorted_priority_queue_tb.sv @@
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned TOP_W        = 32;
    localparam int unsigned MAX_PRINTED  = 100;

    // One expected result transfer.
    typedef struct {
        logic [TOP_W-1:0] top;
        t_status          status;
        logic [OCC_W-1:0] occ;
    } t_queue_result;

    // Command mixes for the random segments.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    // Receiver back-pressure patterns.
    typedef enum int {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_pattern;

    // Keeps its own sorted copy of the queue and the results it still owes.
    class queue_scoreboard;
        t_value        held[$];
        t_queue_result owed[$];
        int unsigned   mismatches   = 0;
        int unsigned   results_seen = 0;
        int unsigned   stored       = 0;
        int unsigned   full_drops   = 0;
        int unsigned   empty_hits   = 0;
        int unsigned   clears       = 0;
        int unsigned   peak         = 0;

        task report(string what, logic [63:0] got, logic [63:0] want);
            if (mismatches < MAX_PRINTED)
                $display("tb: mismatch at %0t ns on %s: got 0x%0h, want 0x%0h",
                         $time, what, got, want);
            mismatches++;
        endtask

        // Apply one accepted command to the shadow queue and queue its result.
        function void note_input(t_cmd c, logic [IN_DATA_W-1:0] d);
            logic signed [63:0] wide;
            t_value             v;
            t_queue_result      r;
            int unsigned        pos;

            wide     = {{(64 - FIELD_W){d[FIELD_W-1]}}, d[FIELD_W-1:0]};
            v        = wide[VALUE_WIDTH-1:0];
            r.top    = '0;
            r.status = ST_OK;
            if (held.size() > 0) begin
                wide  = {{(64 - VALUE_WIDTH){held[0][VALUE_WIDTH-1]}}, held[0]};
                r.top = wide[TOP_W-1:0];
            end

            case (c)
                CMD_INSERT: begin
                    if (held.size() >= DEPTH) begin
                        r.status = ST_FULL;
                        full_drops++;
                    end else begin
                        // Equal values go behind the entries already held.
                        pos = held.size();
                        for (int i = 0; i < held.size(); i++) begin
                            if ($signed(v) > $signed(held[i])) begin
                                pos = i;
                                break;
                            end
                        end
                        held.insert(pos, v);
                        stored++;
                    end
                end
                CMD_PEEK: begin
                    if (held.size() == 0) begin
                        r.status = ST_EMPTY;
                        empty_hits++;
                    end
                end
                CMD_REMOVE: begin
                    if (held.size() == 0) begin
                        r.status = ST_EMPTY;
                        empty_hits++;
                    end else begin
                        void'(held.pop_front());
                    end
                end
                default: begin
                    held.delete();
                    clears++;
                end
            endcase

            if (held.size() > peak)
                peak = held.size();
            r.occ = OCC_W'(held.size());
            owed.push_back(r);
        endfunction

        // Compare one result transfer with the oldest owed result.
        task check_result(logic [OUT_DATA_W-1:0] d, logic [STATUS_W-1:0] st);
            t_queue_result r;

            if (owed.size() == 0) begin
                report("unexpected result", d, '0);
                return;
            end
            r = owed.pop_front();
            results_seen++;
            if (d[TOP_W-1:0] !== r.top)
                report("top_value", d[TOP_W-1:0], r.top);
            if (d[TOP_W+OCC_W-1:TOP_W] !== r.occ)
                report("occupancy", d[TOP_W+OCC_W-1:TOP_W], r.occ);
            if (d[OUT_DATA_W-1:TOP_W+OCC_W] !== '0)
                report("padding", d[OUT_DATA_W-1:TOP_W+OCC_W], '0);
            if (st !== r.status)
                report("status", st, r.status);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    queue_scoreboard queue_sb;
    int unsigned     burst_left = 10;
    t_rx_pattern     rx_pattern = RX_ALWAYS;
    int unsigned     rx_left    = 0;
    int unsigned     rx_phase   = 0;

    sorted_priority_queue dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver switches to a randomly chosen stall pattern when its countdown runs out.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_pattern <= t_rx_pattern'($urandom_range(0, 3));
            rx_left    <= $urandom_range(32, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_pattern)
            RX_ALWAYS:   m_axis_tready <= 1'b1;
            RX_HALF:     m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:     m_axis_tready <= ((rx_phase % 5) < 2);
        endcase
    end

    // Transfers on both sides are sampled at the clock edge; results first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                queue_sb.check_result(m_axis_tdata, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                queue_sb.note_input(t_cmd'(s_axis_tuser), s_axis_tdata);
        end
    end

    // Present one command and hold it until the transfer completes; bursts end
    // in a random gap.
    task automatic send_item(input t_cmd c, input logic [IN_DATA_W-1:0] d);
        int unsigned gap;

        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= c;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 60);
        end
    endtask

    // Hold off the sender until every owed result has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (queue_sb.owed.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [IN_DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1, 2: return IN_DATA_W'($urandom);
            // Narrow range so that equal values are common.
            3: return IN_DATA_W'($urandom_range(0, 8) - 4);
            4: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hffff_ffff;
                    default: return 32'h0000_0001;
                endcase
            end
            default: return IN_DATA_W'($urandom_range(0, 511) - 256);
        endcase
    endfunction

    function automatic t_cmd pick_cmd(input t_mix mix);
        int unsigned r;

        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (r < 85) return CMD_INSERT;
                if (r < 92) return CMD_PEEK;
                return CMD_REMOVE;
            end
            MIX_DRAIN: begin
                if (r < 25) return CMD_INSERT;
                if (r < 40) return CMD_PEEK;
                if (r < 98) return CMD_REMOVE;
                return CMD_CLEAR;
            end
            default: begin
                if (r < 45) return CMD_INSERT;
                if (r < 65) return CMD_PEEK;
                if (r < 95) return CMD_REMOVE;
                return CMD_CLEAR;
            end
        endcase
    endfunction

    // Run limit.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int unsigned sent;
        int unsigned seg_left;
        t_mix        mix;

        queue_sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_PEEK;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue: peek, remove and clear, then inserts at the value extremes.
        send_item(CMD_PEEK,   32'h1234_5678);
        send_item(CMD_REMOVE, 32'hffff_ffff);
        send_item(CMD_CLEAR,  32'h0000_0000);
        send_item(CMD_INSERT, 32'h8000_0000);
        send_item(CMD_INSERT, 32'h7fff_ffff);
        send_item(CMD_INSERT, 32'h0000_0000);
        send_item(CMD_INSERT, 32'hffff_ffff);
        // Duplicates of values already held.
        send_item(CMD_INSERT, 32'h7fff_ffff);
        send_item(CMD_INSERT, 32'hffff_ffff);
        send_item(CMD_PEEK,   32'h5555_5555);
        send_item(CMD_REMOVE, 32'haaaa_aaaa);
        send_item(CMD_REMOVE, 32'h0000_0000);
        send_item(CMD_PEEK,   32'h0000_0000);
        send_item(CMD_CLEAR,  32'hdead_beef);
        send_item(CMD_PEEK,   32'h0000_0000);
        send_item(CMD_INSERT, 32'h0000_0001);
        wait_drained();

        // Random segments; the first one fills the queue past capacity.
        sent     = 0;
        mix      = MIX_FILL;
        seg_left = 40;
        while (sent < RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                if ($urandom_range(0, 3) == 0)
                    wait_drained();
                mix      = t_mix'($urandom_range(0, 2));
                seg_left = $urandom_range(20, 80);
            end
            send_item(pick_cmd(mix), pick_value());
            sent++;
            seg_left--;
        end
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("tb: %0d results checked; %0d values stored, %0d inserts dropped when full.",
                 queue_sb.results_seen, queue_sb.stored, queue_sb.full_drops);
        $display("tb: %0d empty peeks or removes, %0d clears, peak occupancy %0d of %0d.",
                 queue_sb.empty_hits, queue_sb.clears, queue_sb.peak, DEPTH);
        if (queue_sb.mismatches == 0 && queue_sb.owed.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
